### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the play sequencer core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is high.
`define CPS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define CPS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPS_ASSERT(lbl, clk, rst, prop, msg)
`define CPS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### design/cps_pkg.sv
// ----------------------------------------------------------------------------
// Play sequencer package
// Phase codes, opcodes, register indexes and the beat structures.
// ----------------------------------------------------------------------------
package cps_pkg;

  // Machine phases, numbered as reported on machine_state.
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_CREDIT     = 3'd1,
    PH_SCREEN     = 3'd2,
    PH_WAIT_STICK = 3'd3,
    PH_RUNNING    = 3'd4,
    PH_WAIT_PRIZE = 3'd5,
    PH_FREEPLAY   = 3'd6,
    PH_MAPPING    = 3'd7
  } phase_t;

  // Input opcodes.
  localparam logic [1:0] OP_UPDATE   = 2'd0;
  localparam logic [1:0] OP_COIN     = 2'd1;
  localparam logic [1:0] OP_FREEPLAY = 2'd2;

  // Stick mapper progress code that ends mapping.
  localparam logic [1:0] MAP_COMPLETE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CREDIT_PULSE = 2'd0;
  localparam logic [1:0] REG_SCREEN_HOLD  = 2'd1;
  localparam logic [1:0] REG_PLAY_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_PRIZE_WAIT   = 2'd3;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] credit_pulse_ms;
    logic [15:0] ready_hold_ms;
    logic [19:0] play_timeout_ms;
    logic [15:0] chute_wait_ms;
  } cfg_t;

  // One captured input beat; the stick lines are already reduced to one flag.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic        config_click;
    logic        freeplay_click;
    logic        start_pressed;
    logic        sticks;
    logic        claw_button;
    logic        prize_sensor;
    logic [1:0]  mapping_result;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  machine_state;
    logic        credit_relay;
    logic        motors_enabled;
    logic        freeplay_active;
    logic        send_start_button;
    logic        send_ready;
    logic        send_start;
    logic        send_claw;
    logic        begin_mapping;
    logic        game_over;
    logic        game_won;
    logic [31:0] game_duration_ms;
  } result_t;

endpackage

### design/coin_op_play_sequencer.sv
// An accepted beat waits in the input register; its result is registered and drives out_valid.
// Throughput: one beat per cycle; the input register and the result register each
// hold one beat, and the input stalls only while a held result is itself stalled.
// Reset (synchronous, rst high) empties both registers, puts the sequencer in idle
// with freeplay off and entry pending, and restores the default timing registers.
// ----------------------------------------------------------------------------
// Coin-op play sequencer
// Claw machine game sequencer with APB timing registers and stall handshakes.
// ----------------------------------------------------------------------------
module coin_op_play_sequencer #(
  parameter int STICK_LINES = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [31:0]            now_ms,
  input  logic                   config_click,
  input  logic                   freeplay_click,
  input  logic                   start_pressed,
  input  logic [STICK_LINES-1:0] stick_active,
  input  logic                   claw_button,
  input  logic                   prize_sensor,
  input  logic [1:0]             mapping_result,
  // Output channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             machine_state,
  output logic                   credit_relay,
  output logic                   motors_enabled,
  output logic                   freeplay_active,
  output logic                   send_start_button,
  output logic                   send_ready,
  output logic                   send_start,
  output logic                   send_claw,
  output logic                   begin_mapping,
  output logic                   game_over,
  output logic                   game_won,
  output logic [31:0]            game_duration_ms
);
  import cps_pkg::*;

  cfg_t    cfg;
  item_t   item;
  item_t   item_in;
  result_t res_comb;
  result_t res;
  logic    in_full;
  logic    out_free;
  logic    fire;
  logic    take;

  // Timing registers.
  cps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake control for the two register stages.
  assign out_free = !out_valid || !out_stall;
  assign fire     = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign take     = in_valid && !in_stall;

  // Pack the input beat.
  always_comb begin
    item_in.opcode         = opcode;
    item_in.now_ms         = now_ms;
    item_in.config_click   = config_click;
    item_in.freeplay_click = freeplay_click;
    item_in.start_pressed  = start_pressed;
    item_in.sticks         = |stick_active;
    item_in.claw_button    = claw_button;
    item_in.prize_sensor   = prize_sensor;
    item_in.mapping_result = mapping_result;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_in;
    end
  end

  // Step logic and sequencer state.
  cps_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .item   (item),
    .cfg    (cfg),
    .result (res_comb)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_comb;
    end
  end

  // Unpack the result beat.
  assign machine_state     = res.machine_state;
  assign credit_relay      = res.credit_relay;
  assign motors_enabled    = res.motors_enabled;
  assign freeplay_active   = res.freeplay_active;
  assign send_start_button = res.send_start_button;
  assign send_ready        = res.send_ready;
  assign send_start        = res.send_start;
  assign send_claw         = res.send_claw;
  assign begin_mapping     = res.begin_mapping;
  assign game_over         = res.game_over;
  assign game_won          = res.game_won;
  assign game_duration_ms  = res.game_duration_ms;

endmodule

### design/cps_regs.sv
// ----------------------------------------------------------------------------
// Play sequencer configuration registers
// APB write and read access to the four timing registers.
// ----------------------------------------------------------------------------
module cps_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cps_pkg::cfg_t cfg
);
  import cps_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes; reset restores the default timings.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.credit_pulse_ms <= 16'd500;
      cfg.ready_hold_ms   <= 16'd2000;
      cfg.play_timeout_ms <= 20'd30000;
      cfg.chute_wait_ms   <= 16'd5000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CREDIT_PULSE: cfg.credit_pulse_ms <= pwdata[15:0];
        REG_SCREEN_HOLD:  cfg.ready_hold_ms   <= pwdata[15:0];
        REG_PLAY_TIMEOUT: cfg.play_timeout_ms <= pwdata[19:0];
        REG_PRIZE_WAIT:   cfg.chute_wait_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_CREDIT_PULSE: prdata = {16'd0, cfg.credit_pulse_ms};
      REG_SCREEN_HOLD:  prdata = {16'd0, cfg.ready_hold_ms};
      REG_PLAY_TIMEOUT: prdata = {12'd0, cfg.play_timeout_ms};
      REG_PRIZE_WAIT:   prdata = {16'd0, cfg.chute_wait_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

### design/cps_core.sv
// ----------------------------------------------------------------------------
// Play sequencer core
// Phase state registers and the single-pass step logic for one beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cps_core #(
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cps_pkg::item_t   item,
  input  cps_pkg::cfg_t    cfg,
  output cps_pkg::result_t result
);
  import cps_pkg::*;

  // State registers.
  phase_t               phase;
  logic                 freeplay;
  logic                 entry_pending;
  logic                 credit_on;
  logic [TIME_BITS-1:0] last_change;
  logic [TIME_BITS-1:0] game_start;

  phase_t               phase_next;
  logic                 freeplay_next;
  logic                 entry_pending_next;
  logic                 credit_on_next;
  logic [TIME_BITS-1:0] last_change_next;
  logic [TIME_BITS-1:0] game_start_next;

  // State after the button clicks of an update pass.
  phase_t               ph_pre;
  logic                 fp_pre;
  logic                 ep_pre;
  logic                 cr_pre;
  logic [TIME_BITS-1:0] lc_pre;

  logic                 upd;
  logic [TIME_BITS-1:0] now_t;
  logic [31:0]          elapsed;
  logic                 credit_done;
  logic                 screen_done;
  logic                 play_done;
  logic                 prize_done;

  assign upd     = (item.opcode == OP_UPDATE);
  assign now_t   = item.now_ms[TIME_BITS-1:0];
  assign elapsed = 32'(now_t - lc_pre);

  assign credit_done = elapsed >= 32'(cfg.credit_pulse_ms);
  assign screen_done = elapsed >= 32'(cfg.ready_hold_ms);
  assign play_done   = item.claw_button || (elapsed > 32'(cfg.play_timeout_ms));
  assign prize_done  = item.prize_sensor || (elapsed >= 32'(cfg.chute_wait_ms));

  // Config click first, then freeplay click, on an update pass.
  always_comb begin
    ph_pre = phase;
    fp_pre = freeplay;
    ep_pre = entry_pending;
    cr_pre = credit_on;
    lc_pre = last_change;
    if (upd) begin
      if (item.config_click) begin
        fp_pre = 1'b0;
        cr_pre = 1'b0;
        ph_pre = PH_MAPPING;
        lc_pre = now_t;
        ep_pre = 1'b1;
      end
      if (item.freeplay_click) begin
        fp_pre = !fp_pre;
        cr_pre = 1'b0;
        ph_pre = fp_pre ? PH_FREEPLAY : PH_IDLE;
        lc_pre = now_t;
        ep_pre = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_next         = ph_pre;
    freeplay_next      = fp_pre;
    entry_pending_next = ep_pre;
    credit_on_next     = cr_pre;
    last_change_next   = lc_pre;
    game_start_next    = game_start;
    unique case (item.opcode)
      OP_COIN: begin
        if (phase == PH_IDLE) begin
          credit_on_next     = 1'b1;
          phase_next         = PH_CREDIT;
          last_change_next   = now_t;
          entry_pending_next = 1'b1;
        end
      end
      OP_FREEPLAY: begin
        freeplay_next      = !freeplay;
        credit_on_next     = 1'b0;
        phase_next         = freeplay ? PH_IDLE : PH_FREEPLAY;
        last_change_next   = now_t;
        entry_pending_next = 1'b1;
      end
      OP_UPDATE: begin
        unique case (ph_pre)
          PH_CREDIT: begin
            if (credit_done) begin
              credit_on_next     = 1'b0;
              phase_next         = fp_pre ? PH_RUNNING : PH_SCREEN;
              last_change_next   = now_t;
              entry_pending_next = 1'b1;
            end
          end
          PH_SCREEN: begin
            entry_pending_next = 1'b0;
            if (screen_done) begin
              phase_next         = PH_WAIT_STICK;
              last_change_next   = now_t;
              entry_pending_next = 1'b1;
            end
          end
          PH_WAIT_STICK: begin
            if (item.sticks) begin
              phase_next         = PH_RUNNING;
              last_change_next   = now_t;
              entry_pending_next = 1'b1;
            end
          end
          PH_FREEPLAY: begin
            entry_pending_next = 1'b0;
            if (item.sticks) begin
              credit_on_next     = 1'b1;
              phase_next         = PH_CREDIT;
              last_change_next   = now_t;
              entry_pending_next = 1'b1;
            end
          end
          PH_RUNNING: begin
            if (ep_pre) begin
              game_start_next    = now_t;
              entry_pending_next = 1'b0;
            end
            if (play_done) begin
              phase_next         = PH_WAIT_PRIZE;
              last_change_next   = now_t;
              entry_pending_next = 1'b1;
            end
          end
          PH_WAIT_PRIZE: begin
            if (prize_done) begin
              phase_next         = fp_pre ? PH_FREEPLAY : PH_IDLE;
              last_change_next   = now_t;
              entry_pending_next = 1'b1;
            end
          end
          PH_MAPPING: begin
            if (item.mapping_result == MAP_COMPLETE) begin
              phase_next         = PH_IDLE;
              last_change_next   = now_t;
              entry_pending_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result beat.
  always_comb begin
    result.machine_state     = phase_next;
    result.credit_relay      = credit_on_next;
    result.motors_enabled    = (phase_next == PH_RUNNING);
    result.freeplay_active   = freeplay_next;
    result.send_start_button = upd && item.start_pressed;
    result.begin_mapping     = upd && item.config_click;
    result.send_ready        = upd && ep_pre &&
                               ((ph_pre == PH_SCREEN) || (ph_pre == PH_FREEPLAY));
    result.send_start        = upd && ep_pre && (ph_pre == PH_RUNNING);
    result.send_claw         = upd && (ph_pre == PH_RUNNING) && play_done;
    result.game_over         = upd && (ph_pre == PH_WAIT_PRIZE) && prize_done;
    result.game_won          = result.game_over && item.prize_sensor;
    result.game_duration_ms  = result.game_over ? 32'(now_t - game_start) : 32'd0;
  end

  // State update on every beat that passes through the core.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      freeplay      <= 1'b0;
      entry_pending <= 1'b1;
      credit_on     <= 1'b0;
      last_change   <= '0;
      game_start    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      freeplay      <= freeplay_next;
      entry_pending <= entry_pending_next;
      credit_on     <= credit_on_next;
      last_change   <= last_change_next;
      game_start    <= game_start_next;
    end
  end

  // The relay is only energized during the credit pulse.
  `CPS_ASSERT(a_credit_phase, clk, rst, credit_on |-> phase == PH_CREDIT, "relay on outside credit")
  // Freeplay never coexists with idle or mapping, and the freeplay phase needs the flag.
  `CPS_ASSERT(a_fp_phase, clk, rst, (!freeplay || (phase != PH_IDLE && phase != PH_MAPPING)) && (phase != PH_FREEPLAY || freeplay), "freeplay flag and phase disagree")
  // A game can only end out of the wait-prize phase.
  `CPS_ASSERT(a_over_src, clk, rst, (step && result.game_over) |-> phase == PH_WAIT_PRIZE, "game over outside wait prize")
  // The phase only moves on a beat.
  `CPS_ASSERT(a_hold, clk, rst, !step |=> $stable(phase), "phase changed without a beat")
  // Reset returns the sequencer to idle.
  `CPS_ASSERT_NR(a_reset, clk, rst |=> phase == PH_IDLE, "phase not idle after reset")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Play sequencer testbench
// Drives update passes, coin and freeplay commands through the stall
// handshake, programs the timing registers over the APB port, and checks
// every result beat against a cycle-free model of the claw machine phases.
// ----------------------------------------------------------------------------
module tb_top;
  import cps_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam logic [1:0] MAP_WAITING  = 2'd0;
  localparam logic [1:0] MAP_STEP     = 2'd1;
  localparam logic [1:0] MAP_RESERVED = 2'd3;

  localparam int PIPE_LATENCY   = 2;
  localparam int WATCHDOG_LIMIT = 2000;

  // One input beat with the full stick bus.
  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic        config_click;
    logic        freeplay_click;
    logic        start_pressed;
    logic [3:0]  stick_active;
    logic        claw_button;
    logic        prize_sensor;
    logic [1:0]  mapping_result;
  } play_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [31:0] now_ms = '0;
  logic        config_click = 1'b0;
  logic        freeplay_click = 1'b0;
  logic        start_pressed = 1'b0;
  logic [3:0]  stick_active = '0;
  logic        claw_button = 1'b0;
  logic        prize_sensor = 1'b0;
  logic [1:0]  mapping_result = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  machine_state;
  logic        credit_relay;
  logic        motors_enabled;
  logic        freeplay_active;
  logic        send_start_button;
  logic        send_ready;
  logic        send_start;
  logic        send_claw;
  logic        begin_mapping;
  logic        game_over;
  logic        game_won;
  logic [31:0] game_duration_ms;

  // Sequencer state as the testbench predicts it.
  phase_t      phase_now;
  logic        freeplay_on;
  logic        entry_due;
  logic        relay_on;
  logic [31:0] changed_at_ms;
  logic [31:0] game_began_ms;
  cfg_t        timing;

  result_t     pending_results[$];
  result_t     want;
  int          failures = 0;
  logic [31:0] wall_ms = '0;
  bit          tx_pause_en = 1'b0;
  bit          rx_pause_en = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  coin_op_play_sequencer dut (.*);

  always #5 clk = ~clk;

  // Gap length in cycles: mostly short, now and then long.
  function automatic int unsigned random_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Put the predicted state back to its reset values.
  function automatic void reset_model();
    phase_now = PH_IDLE;
    freeplay_on = 1'b0;
    entry_due = 1'b1;
    relay_on = 1'b0;
    changed_at_ms = '0;
    game_began_ms = '0;
    timing.credit_pulse_ms = 16'd500;
    timing.ready_hold_ms = 16'd2000;
    timing.play_timeout_ms = 20'd30000;
    timing.chute_wait_ms = 16'd5000;
  endfunction

  // Every phase change stamps the time and marks the new phase as just entered.
  function automatic void enter_phase(phase_t next, logic [31:0] t_ms);
    phase_now = next;
    changed_at_ms = t_ms;
    entry_due = 1'b1;
  endfunction

  function automatic void toggle_freeplay(logic [31:0] t_ms);
    freeplay_on = !freeplay_on;
    relay_on = 1'b0;
    enter_phase(freeplay_on ? PH_FREEPLAY : PH_IDLE, t_ms);
  endfunction

  // Advance the predicted sequencer by one beat and return its result.
  function automatic result_t play_step(play_cmd_t c);
    result_t     r;
    logic [31:0] elapsed;
    logic        sticks;
    r = '0;
    sticks = |c.stick_active;
    if (c.opcode == OP_COIN) begin
      if (phase_now == PH_IDLE) begin
        relay_on = 1'b1;
        enter_phase(PH_CREDIT, c.now_ms);
      end
    end else if (c.opcode == OP_FREEPLAY) begin
      toggle_freeplay(c.now_ms);
    end else if (c.opcode == OP_UPDATE) begin
      // Clicks land first, then the phase logic sees the resulting phase.
      if (c.config_click) begin
        freeplay_on = 1'b0;
        relay_on = 1'b0;
        enter_phase(PH_MAPPING, c.now_ms);
        r.begin_mapping = 1'b1;
      end
      if (c.freeplay_click) toggle_freeplay(c.now_ms);
      r.send_start_button = c.start_pressed;
      elapsed = c.now_ms - changed_at_ms;
      case (phase_now)
        PH_CREDIT: begin
          if (elapsed >= 32'(timing.credit_pulse_ms)) begin
            relay_on = 1'b0;
            enter_phase(freeplay_on ? PH_RUNNING : PH_SCREEN, c.now_ms);
          end
        end
        PH_SCREEN: begin
          if (entry_due) begin
            r.send_ready = 1'b1;
            entry_due = 1'b0;
          end
          if (elapsed >= 32'(timing.ready_hold_ms)) enter_phase(PH_WAIT_STICK, c.now_ms);
        end
        PH_WAIT_STICK: begin
          if (sticks) enter_phase(PH_RUNNING, c.now_ms);
        end
        PH_FREEPLAY: begin
          if (entry_due) begin
            r.send_ready = 1'b1;
            entry_due = 1'b0;
          end
          if (sticks) begin
            relay_on = 1'b1;
            enter_phase(PH_CREDIT, c.now_ms);
          end
        end
        PH_RUNNING: begin
          if (entry_due) begin
            r.send_start = 1'b1;
            game_began_ms = c.now_ms;
            entry_due = 1'b0;
          end
          if (c.claw_button || elapsed > 32'(timing.play_timeout_ms)) begin
            r.send_claw = 1'b1;
            enter_phase(PH_WAIT_PRIZE, c.now_ms);
          end
        end
        PH_WAIT_PRIZE: begin
          if (c.prize_sensor || elapsed >= 32'(timing.chute_wait_ms)) begin
            r.game_over = 1'b1;
            r.game_won = c.prize_sensor;
            r.game_duration_ms = c.now_ms - game_began_ms;
            enter_phase(freeplay_on ? PH_FREEPLAY : PH_IDLE, c.now_ms);
          end
        end
        PH_MAPPING: begin
          if (c.mapping_result == MAP_COMPLETE) enter_phase(PH_IDLE, c.now_ms);
        end
        default: begin
        end
      endcase
    end
    r.machine_state = phase_now;
    r.credit_relay = relay_on;
    r.motors_enabled = (phase_now == PH_RUNNING);
    r.freeplay_active = freeplay_on;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] expected_val,
                                        logic [31:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s: expected %0h, got %0h", name, expected_val, actual_val);
      failures++;
    end
  endfunction

  function automatic play_cmd_t make_cmd(logic [1:0] op, logic [31:0] t_ms);
    play_cmd_t c;
    c.opcode = op;
    c.now_ms = t_ms;
    c.config_click = 1'b0;
    c.freeplay_click = 1'b0;
    c.start_pressed = 1'b0;
    c.stick_active = '0;
    c.claw_button = 1'b0;
    c.prize_sensor = 1'b0;
    c.mapping_result = MAP_WAITING;
    return c;
  endfunction

  // Next timestamp: often right at the threshold of the current phase.
  function automatic logic [31:0] next_time_ms();
    logic [31:0] limit_ms;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case (phase_now)
      PH_CREDIT:     limit_ms = 32'(timing.credit_pulse_ms);
      PH_SCREEN:     limit_ms = 32'(timing.ready_hold_ms);
      PH_RUNNING:    limit_ms = 32'(timing.play_timeout_ms);
      PH_WAIT_PRIZE: limit_ms = 32'(timing.chute_wait_ms);
      default:       limit_ms = 32'd1000;
    endcase
    if (pick < 25) return changed_at_ms + limit_ms + $urandom_range(0, 2) - 1;
    if (pick < 55) return wall_ms + $urandom_range(0, 50);
    if (pick < 85) return wall_ms + $urandom_range(0, limit_ms + limit_ms / 4 + 10);
    if (pick < 95) return wall_ms + $urandom_range(0, 1100000);
    return $urandom;
  endfunction

  // A plausible next beat for the phase the machine is in.
  function automatic play_cmd_t next_game_cmd();
    play_cmd_t   c;
    int unsigned roll;
    wall_ms = next_time_ms();
    c = make_cmd(OP_UPDATE, wall_ms);
    roll = $urandom_range(0, 99);
    if (phase_now == PH_IDLE) begin
      if (roll < 70) c.opcode = OP_COIN;
      else if (roll < 73) c.opcode = OP_FREEPLAY;
    end else if (roll < 3) begin
      c.opcode = OP_COIN;
    end else if (roll < 5) begin
      c.opcode = OP_FREEPLAY;
    end
    c.config_click = ($urandom_range(0, 99) < 3);
    c.freeplay_click = ($urandom_range(0, 99) < 3);
    c.start_pressed = 1'($urandom_range(0, 1));
    c.stick_active = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(1, 15));
    c.claw_button = (phase_now == PH_RUNNING) ? ($urandom_range(0, 99) < 15)
                                              : 1'($urandom_range(0, 1));
    c.prize_sensor = (phase_now == PH_WAIT_PRIZE) ? ($urandom_range(0, 99) < 30)
                                                  : 1'($urandom_range(0, 1));
    c.mapping_result = 2'($urandom_range(0, 3));
    return c;
  endfunction

  // Present one beat, wait until it is taken, and record what it must produce.
  task automatic send_cmd(input play_cmd_t c);
    int unsigned pause;
    pause = (tx_pause_en && $urandom_range(0, 3) == 0) ? random_gap() : 0;
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= c.opcode;
    now_ms <= c.now_ms;
    config_click <= c.config_click;
    freeplay_click <= c.freeplay_click;
    start_pressed <= c.start_pressed;
    stick_active <= c.stick_active;
    claw_button <= c.claw_button;
    prize_sensor <= c.prize_sensor;
    mapping_result <= c.mapping_result;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(play_step(c));
  endtask

  // Hold the input until every expected result is back, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // APB write of one timing register, followed by a read back.
  task automatic write_timing(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    case (idx)
      REG_CREDIT_PULSE: timing.credit_pulse_ms = value[15:0];
      REG_SCREEN_HOLD:  timing.ready_hold_ms = value[15:0];
      REG_PLAY_TIMEOUT: timing.play_timeout_ms = value[19:0];
      default:          timing.chute_wait_ms = value[15:0];
    endcase
    stored = (idx == REG_PLAY_TIMEOUT) ? {12'd0, value[19:0]} : {16'd0, value[15:0]};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("prdata", stored, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    // Return the bus to idle between transfers.
    @(posedge clk);
  endtask

  task automatic program_timing(input logic [15:0] credit_ms, input logic [15:0] screen_ms,
                                input logic [19:0] timeout_ms, input logic [15:0] prize_ms);
    drain_results();
    write_timing(REG_CREDIT_PULSE, 32'(credit_ms));
    write_timing(REG_SCREEN_HOLD, 32'(screen_ms));
    write_timing(REG_PLAY_TIMEOUT, 32'(timeout_ms));
    write_timing(REG_PRIZE_WAIT, 32'(prize_ms));
  endtask

  task automatic run_games(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        tx_pause_en = ($urandom_range(0, 2) != 0);
        rx_pause_en = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 149) == 0) drain_results();
      send_cmd(next_game_cmd());
    end
  endtask

  // Walk one full game, a freeplay game, mapping mode and a timestamp wrap
  // with the reset timing values.
  task automatic test_directed_paths();
    play_cmd_t c;
    tx_pause_en = 1'b0;
    rx_pause_en = 1'b0;
    // An unknown opcode with every field at its top changes nothing.
    c = make_cmd(OP_UNKNOWN, 32'hFFFF_FFFF);
    c.config_click = 1'b1;
    c.freeplay_click = 1'b1;
    c.start_pressed = 1'b1;
    c.stick_active = 4'hF;
    c.claw_button = 1'b1;
    c.prize_sensor = 1'b1;
    c.mapping_result = MAP_RESERVED;
    send_cmd(c);
    // Idle pass with everything but the clicks set: only the start message.
    c.opcode = OP_UPDATE;
    c.config_click = 1'b0;
    c.freeplay_click = 1'b0;
    send_cmd(c);
    // Coin, then a second coin outside idle that must be ignored.
    send_cmd(make_cmd(OP_COIN, 32'd1000));
    send_cmd(make_cmd(OP_COIN, 32'd1001));
    // Credit pulse ends exactly at its threshold.
    send_cmd(make_cmd(OP_UPDATE, 32'd1499));
    send_cmd(make_cmd(OP_UPDATE, 32'd1500));
    send_cmd(make_cmd(OP_UPDATE, 32'd1500));
    send_cmd(make_cmd(OP_UPDATE, 32'd3499));
    send_cmd(make_cmd(OP_UPDATE, 32'd3500));
    send_cmd(make_cmd(OP_UPDATE, 32'd3600));
    c = make_cmd(OP_UPDATE, 32'd3700);
    c.stick_active = 4'b1000;
    send_cmd(c);
    // Play timeout is a strict comparison.
    send_cmd(make_cmd(OP_UPDATE, 32'd3800));
    send_cmd(make_cmd(OP_UPDATE, 32'd33700));
    send_cmd(make_cmd(OP_UPDATE, 32'd33701));
    send_cmd(make_cmd(OP_UPDATE, 32'd38700));
    send_cmd(make_cmd(OP_UPDATE, 32'd38701));
    // Freeplay game ended by the claw on the first running pass and a prize.
    send_cmd(make_cmd(OP_FREEPLAY, 32'd40000));
    c = make_cmd(OP_UPDATE, 32'd40010);
    c.stick_active = 4'b0001;
    send_cmd(c);
    send_cmd(make_cmd(OP_UPDATE, 32'd40510));
    c = make_cmd(OP_UPDATE, 32'd40600);
    c.claw_button = 1'b1;
    send_cmd(c);
    c = make_cmd(OP_UPDATE, 32'd40700);
    c.prize_sensor = 1'b1;
    send_cmd(c);
    // Config and freeplay clicks in the same pass: freeplay wins the phase.
    c = make_cmd(OP_UPDATE, 32'd41000);
    c.config_click = 1'b1;
    c.freeplay_click = 1'b1;
    send_cmd(c);
    // Mapping holds on step-done and the reserved code, leaves on complete.
    c = make_cmd(OP_UPDATE, 32'd41100);
    c.config_click = 1'b1;
    c.mapping_result = MAP_STEP;
    send_cmd(c);
    c = make_cmd(OP_UPDATE, 32'd41200);
    c.mapping_result = MAP_RESERVED;
    send_cmd(c);
    c.mapping_result = MAP_COMPLETE;
    send_cmd(c);
    // Elapsed time across the timestamp wrap.
    send_cmd(make_cmd(OP_COIN, 32'hFFFF_FF00));
    send_cmd(make_cmd(OP_UPDATE, 32'h0000_00F4));
  endtask

  // Games with every timer at zero and then at its largest value.
  task automatic test_timing_extremes();
    program_timing(16'd0, 16'd0, 20'd0, 16'd0);
    run_games(250);
    program_timing(16'hFFFF, 16'hFFFF, 20'hF_FFFF, 16'hFFFF);
    run_games(250);
  endtask

  // Games under several random timer settings, ending on the reset values.
  task automatic test_random_timing();
    for (int k = 0; k < 2; k++) begin
      program_timing(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                     20'($urandom_range(0, 600)), 16'($urandom_range(0, 300)));
      run_games(150);
    end
    program_timing(16'($urandom), 16'($urandom), 20'($urandom), 16'($urandom));
    run_games(100);
    program_timing(16'd500, 16'd2000, 20'd30000, 16'd5000);
    run_games(50);
  endtask

  // Unstructured beats: any opcode, any timestamp, any levels.
  task automatic test_noise();
    play_cmd_t c;
    for (int n = 0; n < 200; n++) begin
      if (n % 50 == 0) begin
        tx_pause_en = ($urandom_range(0, 1) != 0);
        rx_pause_en = ($urandom_range(0, 1) != 0);
      end
      c = make_cmd(2'($urandom_range(0, 3)), $urandom);
      c.config_click = 1'($urandom_range(0, 1));
      c.freeplay_click = 1'($urandom_range(0, 1));
      c.start_pressed = 1'($urandom_range(0, 1));
      c.stick_active = 4'($urandom_range(0, 15));
      c.claw_button = 1'($urandom_range(0, 1));
      c.prize_sensor = 1'($urandom_range(0, 1));
      c.mapping_result = 2'($urandom_range(0, 3));
      send_cmd(c);
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (rx_pause_en && $urandom_range(0, 5) == 0) stall_left = random_gap();
    out_stall <= (stall_left != 0);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no expectation waiting");
        failures++;
      end else begin
        want = pending_results.pop_front();
        compare_field("machine_state", 32'(want.machine_state), 32'(machine_state));
        compare_field("credit_relay", 32'(want.credit_relay), 32'(credit_relay));
        compare_field("motors_enabled", 32'(want.motors_enabled), 32'(motors_enabled));
        compare_field("freeplay_active", 32'(want.freeplay_active), 32'(freeplay_active));
        compare_field("send_start_button", 32'(want.send_start_button),
                      32'(send_start_button));
        compare_field("send_ready", 32'(want.send_ready), 32'(send_ready));
        compare_field("send_start", 32'(want.send_start), 32'(send_start));
        compare_field("send_claw", 32'(want.send_claw), 32'(send_claw));
        compare_field("begin_mapping", 32'(want.begin_mapping), 32'(begin_mapping));
        compare_field("game_over", 32'(want.game_over), 32'(game_over));
        compare_field("game_won", 32'(want.game_won), 32'(game_won));
        compare_field("game_duration_ms", want.game_duration_ms, game_duration_ms);
      end
    end
  end

  // Watchdog: too long without any beat or register access ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_paths();
    test_timing_extremes();
    test_random_timing();
    test_noise();
    drain_results();
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/cps_pkg.sv
design/cps_regs.sv
design/cps_core.sv
design/coin_op_play_sequencer.sv
bench/tb_top.sv
